/* src/hpt_pkg.sv */
// Shared constants of the homogeneous point transform.
// Used by the top level, the test checker and the testbench; depends on nothing else.
package hpt_pkg;

    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 64;
    localparam int SLOT_W   = 16;
    localparam int NUM_COLS = 4;

    localparam logic [1:0] REG_COL0  = 2'd0;
    localparam logic [1:0] REG_COL1  = 2'd1;
    localparam logic [1:0] REG_COL2  = 2'd2;
    localparam logic [1:0] REG_TRANS = 2'd3;

    localparam logic [DATA_W-1:0] RESET_COL0  = 64'h0000_0000_0000_1000;
    localparam logic [DATA_W-1:0] RESET_COL1  = 64'h0000_0000_1000_0000;
    localparam logic [DATA_W-1:0] RESET_COL2  = 64'h0000_1000_0000_0000;
    localparam logic [DATA_W-1:0] RESET_TRANS = 64'h1000_0000_0000_0000;

endpackage

/* src/hpt_div_lane.sv */
// Pipelined signed divider lane: (t << frac) / w with saturation, one quotient bit per stage.
// Depends on nothing but its parameters.
module hpt_div_lane #(
    parameter int COORD_WIDTH = 32,
    parameter int SUM_WIDTH   = 50
) (
    input  logic                          clk,
    input  logic                          en,
    input  logic signed [SUM_WIDTH-1:0]   t,
    input  logic signed [SUM_WIDTH-1:0]   w,
    output logic signed [COORD_WIDTH-1:0] q,
    output logic                          sat
);

    localparam int FRAC = COORD_WIDTH / 2;
    localparam int NW   = SUM_WIDTH + FRAC;
    localparam int RW   = SUM_WIDTH + COORD_WIDTH;

    logic [SUM_WIDTH-1:0] t_abs;
    logic [SUM_WIDTH-1:0] w_abs;

    logic [NW-1:0]        num_a_reg;
    logic [SUM_WIDTH-1:0] den_a_reg;
    logic                 neg_a_reg;

    logic [RW-1:0]          rem_reg [COORD_WIDTH+1];
    logic [SUM_WIDTH-1:0]   den_reg [COORD_WIDTH+1];
    logic [COORD_WIDTH-1:0] quo_reg [COORD_WIDTH+1];
    logic                   neg_reg [COORD_WIDTH+1];
    logic                   hi_reg  [COORD_WIDTH+1];

    logic [COORD_WIDTH-1:0] lim;
    logic [COORD_WIDTH-1:0] mag;
    logic                   big;

    assign t_abs = t[SUM_WIDTH-1] ? SUM_WIDTH'(-t) : SUM_WIDTH'(t);
    assign w_abs = w[SUM_WIDTH-1] ? SUM_WIDTH'(-w) : SUM_WIDTH'(w);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_a_reg <= {t_abs, {FRAC{1'b0}}};
            den_a_reg <= w_abs;
            neg_a_reg <= t[SUM_WIDTH-1] ^ w[SUM_WIDTH-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= RW'(num_a_reg);
            den_reg[0] <= den_a_reg;
            quo_reg[0] <= '0;
            neg_reg[0] <= neg_a_reg;
            hi_reg[0]  <= ((RW + 1)'(num_a_reg)) >=
                          ((RW + 1)'({den_a_reg, {COORD_WIDTH{1'b0}}}));
        end
    end

    for (genvar k = 0; k < COORD_WIDTH; k++)
    begin : g_step
        localparam int BIT = COORD_WIDTH - 1 - k;
        logic [RW-1:0] sh;
        logic          take;

        assign sh   = RW'(den_reg[k]) << BIT;
        assign take = rem_reg[k] >= sh;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1] <= take ? rem_reg[k] - sh : rem_reg[k];
                den_reg[k+1] <= den_reg[k];
                quo_reg[k+1] <= quo_reg[k] | (COORD_WIDTH'(take) << BIT);
                neg_reg[k+1] <= neg_reg[k];
                hi_reg[k+1]  <= hi_reg[k];
            end
        end
    end

    assign lim = neg_reg[COORD_WIDTH] ? {1'b1, {(COORD_WIDTH-1){1'b0}}}
                                      : {1'b0, {(COORD_WIDTH-1){1'b1}}};
    assign big = hi_reg[COORD_WIDTH] || (quo_reg[COORD_WIDTH] > lim);
    assign mag = big ? lim : quo_reg[COORD_WIDTH];
    assign q   = neg_reg[COORD_WIDTH] ? $signed(-mag) : $signed(mag);
    assign sat = big;

endmodule

/* src/homogeneous_point_transform.sv */
// Homogeneous point transform: 4x4 column-major matrix times (x,y,z,1), then divide by w.
// Depends on hpt_pkg and hpt_div_lane.
// Result path: product registers, row sums, divider lanes, output registers.
// Throughput: one item per cycle while the result is not stalled; the divider has one pipeline stage per quotient bit.
// A stalled result freezes the whole pipeline; no item is lost or repeated.
// Reset clears the valid bits and loads the identity matrix.
module homogeneous_point_transform #(
    parameter int COORD_WIDTH = 32,
    parameter int COEF_WIDTH  = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [hpt_pkg::ADDR_W-1:0]        paddr,
    input  logic [hpt_pkg::DATA_W-1:0]        pwdata,
    output logic [hpt_pkg::DATA_W-1:0]        prdata,
    output logic                              pready,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [COORD_WIDTH-1:0]     in_x,
    input  logic signed [COORD_WIDTH-1:0]     in_y,
    input  logic signed [COORD_WIDTH-1:0]     in_z,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [COORD_WIDTH-1:0]     out_x,
    output logic signed [COORD_WIDTH-1:0]     out_y,
    output logic signed [COORD_WIDTH-1:0]     out_z,
    output logic                              w_zero,
    output logic                              overflow
);

    localparam int FRAC     = COORD_WIDTH / 2;
    localparam int PW       = COORD_WIDTH + COEF_WIDTH;
    localparam int SW       = PW + 2;
    localparam int LANE_LAT = COORD_WIDTH + 2;

    logic [hpt_pkg::DATA_W-1:0] col_reg [hpt_pkg::NUM_COLS];
    logic [1:0]                 reg_idx;
    logic                       en;

    logic signed [COORD_WIDTH-1:0] pt [3];
    logic signed [PW-1:0] prod_reg [4][4];
    logic signed [SW-1:0] sum_reg  [4];
    logic                 v1_reg;
    logic                 v2_reg;
    logic [LANE_LAT-1:0]  lv_reg;
    logic [LANE_LAT-1:0]  wz_reg;

    logic signed [COORD_WIDTH-1:0] lane_q   [3];
    logic                          lane_sat [3];

    logic                          out_valid_reg;
    logic signed [COORD_WIDTH-1:0] out_x_reg;
    logic signed [COORD_WIDTH-1:0] out_y_reg;
    logic signed [COORD_WIDTH-1:0] out_z_reg;
    logic                          w_zero_reg;
    logic                          overflow_reg;

    assign reg_idx = paddr[4:3];
    assign pready  = 1'b1;
    assign prdata  = col_reg[reg_idx];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg[hpt_pkg::REG_COL0]  <= hpt_pkg::RESET_COL0;
            col_reg[hpt_pkg::REG_COL1]  <= hpt_pkg::RESET_COL1;
            col_reg[hpt_pkg::REG_COL2]  <= hpt_pkg::RESET_COL2;
            col_reg[hpt_pkg::REG_TRANS] <= hpt_pkg::RESET_TRANS;
        end
        else if (psel && penable && pwrite && pready)
        begin
            col_reg[reg_idx] <= pwdata;
        end
    end

    assign en       = !(out_valid_reg && out_stall);
    assign in_stall = !en;

    assign pt[0] = in_x;
    assign pt[1] = in_y;
    assign pt[2] = in_z;

    for (genvar r = 0; r < 4; r++)
    begin : g_row
        for (genvar c = 0; c < 4; c++)
        begin : g_col
            logic signed [COEF_WIDTH-1:0] cf;
            logic signed [PW-1:0]         p;

            assign cf = $signed(col_reg[c][hpt_pkg::SLOT_W*r +: COEF_WIDTH]);
            if (c < 3)
            begin : g_mul
                assign p = PW'(cf) * PW'(pt[c]);
            end
            else
            begin : g_one
                assign p = PW'(cf) <<< FRAC;
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    prod_reg[r][c] <= p;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sum_reg[r] <= SW'(prod_reg[r][0]) + SW'(prod_reg[r][1])
                            + SW'(prod_reg[r][2]) + SW'(prod_reg[r][3]);
            end
        end
    end

    for (genvar r = 0; r < 3; r++)
    begin : g_lane
        hpt_div_lane #(
            .COORD_WIDTH (COORD_WIDTH),
            .SUM_WIDTH   (SW)
        ) u_lane (
            .clk (clk),
            .en  (en),
            .t   (sum_reg[r]),
            .w   (sum_reg[3]),
            .q   (lane_q[r]),
            .sat (lane_sat[r])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            lv_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg        <= in_valid;
            v2_reg        <= v1_reg;
            lv_reg        <= {lv_reg[LANE_LAT-2:0], v2_reg};
            out_valid_reg <= lv_reg[LANE_LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            wz_reg       <= {wz_reg[LANE_LAT-2:0], sum_reg[3] == '0};
            w_zero_reg   <= wz_reg[LANE_LAT-1];
            out_x_reg    <= wz_reg[LANE_LAT-1] ? '0 : lane_q[0];
            out_y_reg    <= wz_reg[LANE_LAT-1] ? '0 : lane_q[1];
            out_z_reg    <= wz_reg[LANE_LAT-1] ? '0 : lane_q[2];
            overflow_reg <= !wz_reg[LANE_LAT-1]
                            && (lane_sat[0] || lane_sat[1] || lane_sat[2]);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;
    assign out_z     = out_z_reg;
    assign w_zero    = w_zero_reg;
    assign overflow  = overflow_reg;

endmodule

/* src/hpt_checker.sv */
// Port-level checks of the homogeneous point transform, attached by bind.
// Depends only on the top level's ports.
module hpt_port_checks #(
    parameter int COORD_WIDTH = 32
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          pready,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic signed [COORD_WIDTH-1:0] out_x,
    input logic signed [COORD_WIDTH-1:0] out_y,
    input logic signed [COORD_WIDTH-1:0] out_z,
    input logic                          w_zero,
    input logic                          overflow
);

    a_zero_w: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && w_zero) |-> (out_x == '0 && out_y == '0 && out_z == '0 && !overflow))
        else $error("zero w result carries data");

    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |-> in_stall)
        else $error("input taken while result is stalled");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_x) && $stable(overflow)))
        else $error("stalled result changed");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("register port not ready");

endmodule

bind homogeneous_point_transform hpt_port_checks #(
    .COORD_WIDTH (COORD_WIDTH)
) u_hpt_port_checks (
    .clk       (clk),
    .rst_n     (rst_n),
    .pready    (pready),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_z     (out_z),
    .w_zero    (w_zero),
    .overflow  (overflow)
);

/* test/hpt_checker.sv */
// Checker for the homogeneous point transform: watches both item channels,
// predicts each result from its own copy of the matrix and compares.
// Depends on hpt_pkg only.
module hpt_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic                         pready,
    input  logic [hpt_pkg::ADDR_W-1:0]   paddr,
    input  logic [hpt_pkg::DATA_W-1:0]   pwdata,
    input  logic                         in_valid,
    input  logic                         in_stall,
    input  logic signed [31:0]           in_x,
    input  logic signed [31:0]           in_y,
    input  logic signed [31:0]           in_z,
    input  logic                         out_valid,
    input  logic                         out_stall,
    input  logic signed [31:0]           out_x,
    input  logic signed [31:0]           out_y,
    input  logic signed [31:0]           out_z,
    input  logic                         w_zero,
    input  logic                         overflow,
    output int                           errors,
    output int                           pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               wz;
        logic               ovf;
    } point_t;

    logic [hpt_pkg::DATA_W-1:0] columns [hpt_pkg::NUM_COLS];
    point_t                     awaited [$];

    function automatic logic signed [15:0] coefficient(int col, int row);
        return columns[col][16*row +: 16];
    endfunction

    function automatic point_t project(logic signed [31:0] x, logic signed [31:0] y,
                                       logic signed [31:0] z);
        logic signed [127:0] p [4];
        logic signed [127:0] w;
        logic signed [127:0] t;
        logic signed [127:0] q;
        point_t              res;
        p[0] = x;
        p[1] = y;
        p[2] = z;
        p[3] = 128'sd65536;
        w = 0;
        for (int c = 0; c < 4; c++)
            w = w + coefficient(c, 3) * p[c];
        res = '0;
        if (w == 0)
        begin
            res.wz = 1'b1;
            return res;
        end
        for (int r = 0; r < 3; r++)
        begin
            t = 0;
            for (int c = 0; c < 4; c++)
                t = t + coefficient(c, r) * p[c];
            q = (t <<< 16) / w;
            if (q > 128'sd2147483647)
            begin
                q = 128'sd2147483647;
                res.ovf = 1'b1;
            end
            else if (q < -128'sd2147483648)
            begin
                q = -128'sd2147483648;
                res.ovf = 1'b1;
            end
            if (r == 0) res.x = q[31:0];
            else if (r == 1) res.y = q[31:0];
            else res.z = q[31:0];
        end
        return res;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch on %s: got %h, expected %h at %t", what, got, want, $realtime);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        point_t want;
        if (!rst_n)
        begin
            columns[hpt_pkg::REG_COL0]  <= hpt_pkg::RESET_COL0;
            columns[hpt_pkg::REG_COL1]  <= hpt_pkg::RESET_COL1;
            columns[hpt_pkg::REG_COL2]  <= hpt_pkg::RESET_COL2;
            columns[hpt_pkg::REG_TRANS] <= hpt_pkg::RESET_TRANS;
            awaited.delete();
            errors = 0;
            pending = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr[4:3] < hpt_pkg::NUM_COLS)
                columns[paddr[4:3]] <= pwdata;
            if (in_valid && !in_stall)
                awaited.push_back(project(in_x, in_y, in_z));
            if (out_valid && !out_stall)
            begin
                if (awaited.size() == 0)
                    report("unexpected item", 0, 0);
                else
                begin
                    want = awaited.pop_front();
                    if (out_x !== want.x) report("out_x", out_x, want.x);
                    if (out_y !== want.y) report("out_y", out_y, want.y);
                    if (out_z !== want.z) report("out_z", out_z, want.z);
                    if (w_zero !== want.wz) report("w_zero", w_zero, want.wz);
                    if (overflow !== want.ovf) report("overflow", overflow, want.ovf);
                end
            end
            pending = awaited.size();
        end
    end
endmodule

/* test/tb_homogeneous_point_transform.sv */
// Top of the homogeneous point transform test: clock, reset, matrix writes and
// point stimulus with random gaps and stalls. Depends on hpt_pkg, hpt_checker and the top level.
module tb_homogeneous_point_transform;
    timeunit 1ns;
    timeprecision 1ps;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [hpt_pkg::ADDR_W-1:0] paddr = '0;
    logic [hpt_pkg::DATA_W-1:0] pwdata = '0;
    logic [hpt_pkg::DATA_W-1:0] prdata;
    logic pready;
    logic in_valid = 1'b0, in_stall, out_valid, out_stall = 1'b0;
    logic signed [31:0] in_x = '0, in_y = '0, in_z = '0;
    logic signed [31:0] out_x, out_y, out_z;
    logic w_zero, overflow;
    int errors, pending;
    bit calm = 1'b0;
    bit hold = 1'b0;

    always #6 clk = ~clk;

    homogeneous_point_transform dut (.*);

    hpt_checker chk (.*);

    task automatic write_column(logic [1:0] idx, logic [63:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic logic [15:0] random_coef();
        unique case ($urandom_range(0, 5))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'($urandom_range(0, 8192)) - 16'd4096;
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic logic [63:0] random_column();
        return {random_coef(), random_coef(), random_coef(), random_coef()};
    endfunction

    function automatic logic [31:0] random_coord();
        unique case ($urandom_range(0, 7))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'($urandom_range(0, 131072)) - 32'd65536;
            default: return $urandom();
        endcase
    endfunction

    task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        while (!calm && $urandom_range(0, 99) < 9)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_x <= x;
        in_y <= y;
        in_z <= z;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (hold)
            out_stall <= 1'b1;
        else
            out_stall <= !calm && ($urandom_range(0, 99) < 9);
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Identity matrix first, with extreme and zero coordinates.
        send_point(32'h7fffffff, 32'h80000000, 32'h0);
        send_point(32'h80000000, 32'h7fffffff, 32'hffffffff);
        send_point(32'h00010000, 32'hffff0000, 32'h00000001);
        drain();

        // w from the bottom row alone: zero w, negative w and overflow.
        write_column(hpt_pkg::REG_COL0, 64'h0000_0000_0000_1000);
        write_column(hpt_pkg::REG_COL1, 64'h0000_0000_1000_0000);
        write_column(hpt_pkg::REG_COL2, 64'h1000_1000_0000_0000);
        write_column(hpt_pkg::REG_TRANS, 64'h0000_7fff_8000_7fff);
        send_point(32'h0, 32'h0, 32'h0);
        send_point(32'h00010000, 32'h00020000, 32'hffff0000);
        send_point(32'h00010000, 32'h00020000, 32'h00000001);
        send_point(32'h7fffffff, 32'h7fffffff, 32'hffffffff);
        send_point(32'h80000000, 32'h80000000, 32'h00000001);
        drain();

        write_column(hpt_pkg::REG_COL0, 64'h8000_8000_8000_8000);
        write_column(hpt_pkg::REG_COL1, 64'h7fff_7fff_7fff_7fff);
        write_column(hpt_pkg::REG_COL2, 64'hffff_ffff_ffff_ffff);
        write_column(hpt_pkg::REG_TRANS, 64'h0000_0000_0000_0000);
        send_point(32'h7fffffff, 32'h80000000, 32'h7fffffff);
        send_point(32'h80000000, 32'h7fffffff, 32'h80000000);
        send_point(32'h00000001, 32'h00000001, 32'h00000000);
        send_point(32'h0, 32'h0, 32'h0);
        drain();

        for (int phase = 0; phase < 10; phase++)
        begin
            for (int c = 0; c < hpt_pkg::NUM_COLS; c++)
                write_column(c[1:0], random_column());
            calm = (phase == 4);
            if (phase == 6)
                fork
                    begin
                        hold = 1'b1;
                        repeat (200) @(posedge clk);
                        hold = 1'b0;
                    end
                join_none
            for (int i = 0; i < 95; i++)
            begin
                if ($urandom_range(0, 19) == 0)
                    send_point(32'h0, 32'h0, 32'h0);
                else
                    send_point(random_coord(), random_coord(), random_coord());
            end
            calm = 1'b0;
            drain();
        end

        if (errors == 0)
            $display("homogeneous_point_transform test passed");
        else
            $display("homogeneous_point_transform test failed");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("homogeneous_point_transform test failed");
        $finish;
    end
endmodule

/* files.f */
src/hpt_pkg.sv
src/hpt_div_lane.sv
src/homogeneous_point_transform.sv
src/hpt_checker.sv
test/hpt_checker.sv
test/tb_homogeneous_point_transform.sv
